/* rtl/mmc3_bank_mapper_scanline_irq_unit_defines.svh */
// Assertion macros shared by the bank mapper RTL.
// Depends on a clock named clk and an active-low reset named arst_n in scope.
`ifndef MMC3_BANK_MAPPER_SCANLINE_IRQ_UNIT_DEFINES_SVH
`define MMC3_BANK_MAPPER_SCANLINE_IRQ_UNIT_DEFINES_SVH

// Condition must hold in the same cycle as the trigger.
`define MMC3_ASSERT_SAME(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("mmc3 assertion failed");

// Condition must hold in the cycle after the trigger.
`define MMC3_ASSERT_NEXT(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("mmc3 assertion failed");

`endif

/* rtl/mmc3_pkg.sv */
// Shared types and constants of the bank mapper with scanline IRQ.
// No dependencies.
package mmc3_pkg;

	localparam int CHR_BANK_BITS = 11;
	localparam int PRG_BANK_BITS = 6;
	localparam int ADDR_W        = 16;
	localparam int DATA_W        = 8;
	localparam int OFFSET_W      = 21;
	localparam int TARGET_W      = 3;
	localparam int PRG_CNT_W     = 7;
	localparam int CHR_CNT_W     = 12;
	localparam int CFG_IDX_W     = 2;
	localparam int CFG_DATA_W    = 12;
	localparam int DIV_STEPS     = 8;
	localparam int DIV_CNT_W     = 3;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_PRG_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CHR_COUNT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PRG_RAM   = 2'd2;

	// Access targets.
	localparam logic [TARGET_W-1:0] TGT_NONE = 3'd0;
	localparam logic [TARGET_W-1:0] TGT_CHR  = 3'd1;
	localparam logic [TARGET_W-1:0] TGT_NT   = 3'd2;
	localparam logic [TARGET_W-1:0] TGT_RAM  = 3'd3;
	localparam logic [TARGET_W-1:0] TGT_ROM  = 3'd4;

	// Address regions (address bits 15..13).
	localparam logic [2:0] RGN_CHR  = 3'd0;
	localparam logic [2:0] RGN_NT   = 3'd1;
	localparam logic [2:0] RGN_RAM  = 3'd3;
	localparam logic [2:0] RGN_BANK = 3'd4;
	localparam logic [2:0] RGN_MIRR = 3'd5;
	localparam logic [2:0] RGN_IRQL = 3'd6;

	localparam logic OP_WRITE = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_EXEC,
		ST_RESP
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic step;
		logic exec;
	} ctl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic bank_data;
	} ctl_sts_t;

endpackage

/* rtl/mmc3_if.sv */
// Request and result channel interfaces of the bank mapper.
// Depends on mmc3_pkg.
interface mmc3_req_if;
	logic                       valid;
	logic                       ready;
	logic                       op;
	logic [mmc3_pkg::ADDR_W-1:0] address;
	logic [mmc3_pkg::DATA_W-1:0] write_data;

	modport source(output valid, op, address, write_data, input ready);
	modport sink(input valid, op, address, write_data, output ready);
endinterface

interface mmc3_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [mmc3_pkg::TARGET_W-1:0] target;
	logic [mmc3_pkg::OFFSET_W-1:0] physical_offset;
	logic [1:0]                    nametable_index;
	logic                          mirror_select;
	logic                          irq_line;

	modport source(output valid, target, physical_offset, nametable_index, mirror_select,
		irq_line, input ready);
	modport sink(input valid, target, physical_offset, nametable_index, mirror_select,
		irq_line, output ready);
endinterface

/* rtl/mmc3_ctrl.sv */
// Controller state machine of the bank mapper: request handshake, divider sequencing.
// Depends on mmc3_pkg and the assertion macro header.
`include "mmc3_bank_mapper_scanline_irq_unit_defines.svh"

module mmc3_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	input  mmc3_pkg::ctl_sts_t sts,
	output mmc3_pkg::ctl_cmd_t cmd
);
	import mmc3_pkg::*;

	state_t               state_q, state_d;
	logic [DIV_CNT_W-1:0] cnt_q, cnt_d;

	// State and step counter registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		cmd       = '0;
		req_ready = 1'b0;
		rsp_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load = 1'b1;
					cnt_d    = '0;
					state_d  = sts.bank_data ? ST_DIV : ST_EXEC;
				end
			end
			ST_DIV: begin
				cmd.step = 1'b1;
				cnt_d    = cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = ST_RESP;
			end
			ST_RESP: begin
				rsp_valid = 1'b1;
				if (rsp_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	`MMC3_ASSERT_SAME(a_no_overlap, rsp_valid, !req_ready)
	`MMC3_ASSERT_NEXT(a_div_done, state_q == ST_DIV && cnt_q == DIV_CNT_W'(DIV_STEPS - 1),
		state_q == ST_EXEC)
	`MMC3_ASSERT_NEXT(a_exec_resp, state_q == ST_EXEC, state_q == ST_RESP)
	`MMC3_ASSERT_NEXT(a_plain_exec, req_valid && req_ready && !sts.bank_data,
		state_q == ST_EXEC)

endmodule

/* rtl/mmc3_dp.sv */
// Datapath of the bank mapper: bank slots, IRQ counter, remainder unit, result register.
// Depends on mmc3_pkg.
module mmc3_dp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  mmc3_pkg::ctl_cmd_t             cmd,
	output mmc3_pkg::ctl_sts_t             sts,
	input  logic                           cfg_we,
	input  logic [mmc3_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [mmc3_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           op,
	input  logic [mmc3_pkg::ADDR_W-1:0]    address,
	input  logic [mmc3_pkg::DATA_W-1:0]    write_data,
	output logic [mmc3_pkg::TARGET_W-1:0]  target,
	output logic [mmc3_pkg::OFFSET_W-1:0]  physical_offset,
	output logic [1:0]                     nametable_index,
	output logic                           mirror_select,
	output logic                           irq_line
);
	import mmc3_pkg::*;

	// Configuration.
	logic [PRG_CNT_W-1:0]     prg_cnt_q;
	logic [CHR_CNT_W-1:0]     chr_cnt_q;
	logic                     ram_q;
	// Mapper state.
	logic [CHR_BANK_BITS-1:0] chr_slot_q [8];
	logic [PRG_BANK_BITS-1:0] prg_slot_q [4];
	logic [7:0]               bsel_q, latch_q, counter_q;
	logic                     reload_q, enable_q, a12_q, pending_q, mirror_q;
	// Item and remainder unit.
	logic                     op_q;
	logic [ADDR_W-1:0]        addr_q;
	logic [DATA_W-1:0]        data_q;
	logic [7:0]               rem_q, dvd_q;

	logic [2:0]               rgn;
	logic [PRG_BANK_BITS-1:0] prg_second_last;
	logic                     chr_sel;
	logic [CHR_CNT_W-1:0]     divisor;
	logic [7:0]               trial, rem_next;
	logic                     a12_rise;
	logic [7:0]               counter_d;
	logic                     reload_d, pending_d, enable_d, mirror_d;
	logic [TARGET_W-1:0]      tgt_d;
	logic [OFFSET_W-1:0]      off_d;
	logic [1:0]               nt_d;

	assign sts.bank_data = (op == OP_WRITE) && (address[15:13] == RGN_BANK) && address[0];

	assign rgn             = addr_q[15:13];
	assign prg_second_last = prg_cnt_q[PRG_BANK_BITS-1:0] - PRG_BANK_BITS'(2);

	// Bank registers 0-5 reduce modulo the CHR count, 6-7 modulo the PRG count.
	assign chr_sel  = (bsel_q[2:0] <= 3'd5);
	assign divisor  = chr_sel ? chr_cnt_q : CHR_CNT_W'(prg_cnt_q);
	assign trial    = {rem_q[6:0], dvd_q[7]};
	assign rem_next = (CHR_CNT_W'(trial) >= divisor) ? trial - divisor[7:0] : trial;

	// Result fields and IRQ update for the item being executed.
	always_comb begin
		tgt_d     = TGT_NONE;
		off_d     = '0;
		nt_d      = '0;
		a12_rise  = 1'b0;
		counter_d = counter_q;
		reload_d  = reload_q;
		pending_d = pending_q;
		enable_d  = enable_q;
		mirror_d  = mirror_q;
		priority if (rgn == RGN_CHR) begin
			tgt_d    = TGT_CHR;
			off_d    = {chr_slot_q[addr_q[12:10]], addr_q[9:0]};
			a12_rise = (op_q != OP_WRITE) && addr_q[12] && !a12_q;
		end else if (rgn == RGN_NT) begin
			tgt_d = TGT_NT;
			off_d = OFFSET_W'(addr_q[9:0]);
			nt_d  = addr_q[11:10];
		end else if (rgn == RGN_RAM) begin
			if (ram_q) begin
				tgt_d = TGT_RAM;
				off_d = OFFSET_W'(addr_q[12:0]);
			end
		end else if (rgn >= RGN_BANK) begin
			if (op_q == OP_WRITE) begin
				unique case (rgn)
					RGN_MIRR: if (!addr_q[0]) mirror_d = data_q[0];
					RGN_IRQL: if (addr_q[0]) reload_d = 1'b1;
					RGN_BANK: ;
					default: begin
						enable_d = addr_q[0];
						if (!addr_q[0]) pending_d = 1'b0;
					end
				endcase
			end else begin
				tgt_d = TGT_ROM;
				off_d = OFFSET_W'({prg_slot_q[rgn[1:0]], addr_q[12:0]});
			end
		end
		// Scanline counter clocked by an A12 rising edge.
		if (a12_rise) begin
			priority if (reload_q) begin
				counter_d = latch_q;
				reload_d  = 1'b0;
			end else if (counter_q == 8'd1) begin
				counter_d = '0;
				if (enable_q) pending_d = 1'b1;
			end else if (counter_q == 8'd0) begin
				counter_d = latch_q;
			end else begin
				counter_d = counter_q - 8'd1;
			end
		end
	end

	// Item capture, remainder steps and result register; no reset needed.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= op;
			addr_q <= address;
			data_q <= write_data;
			rem_q  <= '0;
			dvd_q  <= (address[0] && bsel_q[2:0] > 3'd5) ? {2'b00, write_data[5:0]}
				: write_data;
		end else if (cmd.step) begin
			rem_q <= rem_next;
			dvd_q <= {dvd_q[6:0], 1'b0};
		end
		if (cmd.exec) begin
			target          <= tgt_d;
			physical_offset <= off_d;
			nametable_index <= nt_d;
			mirror_select   <= mirror_d;
			irq_line        <= pending_d;
		end
	end

	// Mapper state and configuration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prg_cnt_q <= PRG_CNT_W'(32);
			chr_cnt_q <= CHR_CNT_W'(256);
			ram_q     <= 1'b1;
			for (int i = 0; i < 8; i++) chr_slot_q[i] <= CHR_BANK_BITS'(i);
			for (int i = 0; i < 3; i++) prg_slot_q[i] <= PRG_BANK_BITS'(30);
			prg_slot_q[3] <= PRG_BANK_BITS'(31);
			bsel_q    <= '0;
			latch_q   <= '0;
			counter_q <= '0;
			reload_q  <= 1'b0;
			enable_q  <= 1'b0;
			a12_q     <= 1'b0;
			pending_q <= 1'b0;
			mirror_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_PRG_COUNT: begin
						prg_cnt_q <= cfg_data[PRG_CNT_W-1:0];
						for (int i = 0; i < 3; i++)
							prg_slot_q[i] <= cfg_data[PRG_BANK_BITS-1:0] - PRG_BANK_BITS'(2);
						prg_slot_q[3] <= cfg_data[PRG_BANK_BITS-1:0] - PRG_BANK_BITS'(1);
					end
					CFG_CHR_COUNT: chr_cnt_q <= cfg_data;
					CFG_PRG_RAM:   ram_q     <= cfg_data[0];
					default: ;
				endcase
			end
			if (cmd.exec) begin
				counter_q <= counter_d;
				reload_q  <= reload_d;
				pending_q <= pending_d;
				enable_q  <= enable_d;
				mirror_q  <= mirror_d;
				if (rgn == RGN_CHR && op_q != OP_WRITE) a12_q <= addr_q[12];
				if (rgn == RGN_IRQL && op_q == OP_WRITE && !addr_q[0]) latch_q <= data_q;
				// Bank select and bank data registers.
				if (rgn == RGN_BANK && op_q == OP_WRITE) begin
					if (!addr_q[0]) begin
						bsel_q <= data_q;
					end else begin
						unique case (bsel_q[2:0])
							3'd0, 3'd1: begin
								chr_slot_q[{bsel_q[7], bsel_q[0], 1'b0}] <=
									CHR_BANK_BITS'({rem_q[7:1], 1'b0});
								chr_slot_q[{bsel_q[7], bsel_q[0], 1'b1}] <=
									CHR_BANK_BITS'({rem_q[7:1], 1'b1});
							end
							3'd2, 3'd3, 3'd4, 3'd5: begin
								chr_slot_q[{~bsel_q[7], 2'(bsel_q[2:0] - 3'd2)}] <=
									CHR_BANK_BITS'(rem_q);
							end
							3'd6: begin
								prg_slot_q[{bsel_q[6], 1'b0}]  <= rem_q[PRG_BANK_BITS-1:0];
								prg_slot_q[{~bsel_q[6], 1'b0}] <= prg_second_last;
							end
							default: prg_slot_q[1] <= rem_q[PRG_BANK_BITS-1:0];
						endcase
					end
				end
			end
		end
	end

endmodule

/* rtl/mmc3_bank_mapper_scanline_irq_unit.sv */
// Top level of the bank mapper with scanline IRQ counter.
// Depends on mmc3_pkg, mmc3_if, mmc3_ctrl and mmc3_dp.
//
// Usage: each request on req is one bus access (op, address, write_data).
// The block answers with one result on rsp: target memory, translated byte
// offset, nametable index, current mirroring bit and the IRQ level after
// the access. The cfg port (cfg_we, cfg_index, cfg_data) sets the PRG and
// CHR bank counts and PRG RAM presence; write it only while idle.
// A taken request passes through the EXEC state, which registers the result,
// then the RESP state, which raises rsp.valid. A bank data write first passes
// through the DIV state, where its bank number goes through an 8-step bit-serial
// remainder unit. One access is in flight at a time: req is ready only in the
// idle state, so no new access is taken until the result has been taken.
// While rsp is stalled the result holds and req stays not ready.
// Reset loads the default bank counts, identity CHR slots, the last two
// PRG banks and clears the IRQ logic; no clearing pass is needed.
module mmc3_bank_mapper_scanline_irq_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	mmc3_req_if.sink                        req,
	mmc3_rsp_if.source                      rsp,
	input  logic                            cfg_we,
	input  logic [mmc3_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mmc3_pkg::CFG_DATA_W-1:0] cfg_data
);
	import mmc3_pkg::*;

	ctl_cmd_t cmd;
	ctl_sts_t sts;

	mmc3_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	mmc3_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.op              (req.op),
		.address         (req.address),
		.write_data      (req.write_data),
		.target          (rsp.target),
		.physical_offset (rsp.physical_offset),
		.nametable_index (rsp.nametable_index),
		.mirror_select   (rsp.mirror_select),
		.irq_line        (rsp.irq_line)
	);

endmodule
